// ----- rtl/urlfe_pkg.sv -----
// ============================================================================
// urlfe_pkg: shared types and constants for the form-field extractor
// Result beat layout, queue interface structs, character codes, register
// indexes and the hex digit helpers used by the front end.
// ============================================================================
package urlfe_pkg;

    // Key register holds at most this many bytes
    localparam int KEY_MAX = 8;

    // Result queue between front and back end
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;

    // Configuration register indexes
    localparam logic [1:0] CFG_KEY_CHARS  = 2'd0;
    localparam logic [1:0] CFG_KEY_LENGTH = 2'd1;
    localparam logic [1:0] CFG_OUT_LIMIT  = 2'd2;

    // Configuration reset values
    localparam logic [63:0] KEY_CHARS_RST  = 64'd0;
    localparam logic [3:0]  KEY_LENGTH_RST = 4'd1;
    localparam logic [7:0]  OUT_LIMIT_RST  = 8'd33;

    // Character codes
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_SPACE = 8'h20;

    typedef enum logic [1:0] {
        PH_SEARCH,
        PH_VALUE,
        PH_DONE
    } phase_t;

    typedef enum logic [1:0] {
        ESC_NONE,
        ESC_PCT,
        ESC_HI
    } esc_t;

    typedef struct packed {
        logic [7:0] value_byte;
        logic       byte_valid;
        logic       field_end;
        logic       key_found;
        logic [6:0] value_length;
    } result_t;

    // Up to two results written into the queue per accepted beat
    typedef struct packed {
        logic [1:0] count;
        result_t    slot0;
        result_t    slot1;
    } push_t;

    // Queue head offered to the back end
    typedef struct packed {
        logic    valid;
        result_t data;
    } head_t;

    // Hex digit: bit 4 flags a digit, bits 3:0 carry its value
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 4'(c - 8'h30)};
        else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
        else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
        return r;
    endfunction

    function automatic logic [7:0] hex_pair(input logic [7:0] a, input logic [7:0] b);
        logic [4:0] h;
        logic [4:0] l;
        logic [7:0] r;
        h = hex_digit(a);
        l = hex_digit(b);
        if (!h[4]) r = 8'd0;
        else if (!l[4]) r = {4'd0, h[3:0]};
        else r = {h[3:0], l[3:0]};
        return r;
    endfunction

endpackage

// ----- rtl/urlfe_front.sv -----
// ============================================================================
// urlfe_front: byte classifier and field state
// Holds the configuration and per-body state, matches the key window,
// decodes escapes and pushes up to two result beats per body byte.
// ============================================================================
module urlfe_front #(
    parameter int KEY_BYTES = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write_en,
    input  logic [1:0]        cfg_index,
    input  logic [63:0]       cfg_data,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [7:0]        body_byte,
    input  logic              body_last,
    input  logic              room_for_two,
    output urlfe_pkg::push_t  push
);
    import urlfe_pkg::*;

    localparam int WIN_BYTES = (KEY_BYTES < KEY_MAX) ? KEY_BYTES : KEY_MAX;
    localparam int WIN_W     = 8 * WIN_BYTES;
    localparam logic [3:0] WIN_LEN = 4'(WIN_BYTES);

    logic [63:0]      key_chars_reg;
    logic [3:0]       key_length_reg;
    logic [7:0]       out_limit_reg;

    logic [WIN_W-1:0] window_reg, window_next;
    logic [3:0]       since_reg, since_next;
    phase_t           phase_reg, phase_next;
    esc_t             esc_reg, esc_next;
    logic [7:0]       fh_reg, fh_next;
    logic [6:0]       emitted_reg, emitted_next;

    logic             acc;
    logic             end_body;
    logic [7:0]       lim_raw;
    logic [6:0]       limit;
    logic [3:0]       key_len;
    logic             key_hit;

    logic             do_a;
    logic [7:0]       a_byte;
    logic             do_plain;
    logic [7:0]       p_byte;
    esc_t             esc_step;
    logic [7:0]       fh_step;

    logic [6:0]       cnt_a;
    logic             a_done;
    logic             plain_live;
    logic             plain_stop;
    logic             emit_p;
    logic [6:0]       cnt_p;
    logic             p_done;
    phase_t           phase_step;

    assign in_stall = !room_for_two;
    assign acc      = in_valid && room_for_two;
    assign end_body = (body_byte == CH_NUL) || body_last;

    // Effective limit: out_limit-1, clamped to 127
    assign lim_raw = (out_limit_reg == 8'd0) ? 8'd0 : out_limit_reg - 8'd1;
    assign limit   = (lim_raw > 8'd127) ? 7'd127 : lim_raw[6:0];
    assign key_len = (key_length_reg > WIN_LEN) ? WIN_LEN : key_length_reg;

    // Key compare: window byte p (newest at 0) against key byte key_len-1-p
    always_comb
    begin
        logic [3:0] q;
        logic [7:0] kb;
        key_hit = (since_reg >= key_len);
        q       = 4'd0;
        kb      = 8'd0;
        for (int p = 0; p < WIN_BYTES; p++)
        begin
            if (4'(p) < key_len)
            begin
                q  = key_len - 4'(p) - 4'd1;
                kb = key_chars_reg[{q[2:0], 3'b000} +: 8];
                if (kb == CH_NUL || window_reg[8*p +: 8] != kb) key_hit = 1'b0;
            end
        end
    end

    // Decode: an optional forced emit, then an optional plain byte
    always_comb
    begin
        do_a     = 1'b0;
        a_byte   = CH_PCT;
        do_plain = 1'b0;
        p_byte   = body_byte;
        esc_step = esc_reg;
        fh_step  = fh_reg;
        if (phase_reg == PH_VALUE)
        begin
            unique case (esc_reg)
                ESC_NONE:
                begin
                    if (body_byte != CH_NUL)
                    begin
                        if (body_byte == CH_PCT && !body_last) esc_step = ESC_PCT;
                        else do_plain = 1'b1;
                    end
                end
                ESC_PCT:
                begin
                    if (body_byte == CH_NUL)
                    begin
                        esc_step = ESC_NONE;
                        do_a     = 1'b1;
                    end
                    else if (body_last)
                    begin
                        esc_step = ESC_NONE;
                        do_a     = 1'b1;
                        do_plain = 1'b1;
                    end
                    else
                    begin
                        fh_step  = body_byte;
                        esc_step = ESC_HI;
                    end
                end
                ESC_HI:
                begin
                    esc_step = ESC_NONE;
                    do_a     = 1'b1;
                    if (body_byte == CH_NUL)
                    begin
                        do_plain = 1'b1;
                        p_byte   = fh_reg;
                    end
                    else
                    begin
                        a_byte = hex_pair(fh_reg, body_byte);
                    end
                end
                default:
                begin
                    esc_step = ESC_NONE;
                end
            endcase
        end
    end

    // Count emitted bytes and decide where the value stops
    assign cnt_a      = emitted_reg + {6'd0, do_a};
    assign a_done     = do_a && (cnt_a >= limit);
    assign plain_live = do_plain && !a_done;
    assign plain_stop = plain_live && ((cnt_a >= limit) || (p_byte == CH_AMP));
    assign emit_p     = plain_live && !plain_stop;
    assign cnt_p      = cnt_a + {6'd0, emit_p};
    assign p_done     = emit_p && (cnt_p >= limit);

    // Next state
    always_comb
    begin
        phase_step   = phase_reg;
        window_next  = window_reg;
        since_next   = since_reg;
        unique case (phase_reg)
            PH_SEARCH:
            begin
                if (body_byte != CH_NUL)
                begin
                    if (body_byte == CH_EQ && key_hit)
                        phase_step = (limit == 7'd0) ? PH_DONE : PH_VALUE;
                    window_next = (window_reg << 8) | WIN_W'(body_byte);
                    if (since_reg < 4'd15) since_next = since_reg + 4'd1;
                end
            end
            PH_VALUE:
            begin
                if (a_done || plain_stop || p_done) phase_step = PH_DONE;
            end
            PH_DONE:
            begin
                phase_step = PH_DONE;
            end
            default:
            begin
                phase_step = PH_SEARCH;
            end
        endcase

        phase_next   = phase_step;
        esc_next     = esc_step;
        fh_next      = fh_step;
        emitted_next = cnt_p;
        if (end_body)
        begin
            window_next  = '0;
            since_next   = 4'd0;
            phase_next   = PH_SEARCH;
            esc_next     = ESC_NONE;
            fh_next      = 8'd0;
            emitted_next = 7'd0;
        end
    end

    // Result beats
    always_comb
    begin
        result_t    ra;
        result_t    rp;
        result_t    r0;
        result_t    r1;
        logic [1:0] n;
        ra            = '0;
        ra.value_byte = a_byte;
        ra.byte_valid = 1'b1;
        rp            = '0;
        rp.value_byte = (p_byte == CH_PLUS) ? CH_SPACE : p_byte;
        rp.byte_valid = 1'b1;
        r0            = '0;
        r1            = '0;
        n             = 2'd0;
        if (do_a)
        begin
            r0 = ra;
            n  = 2'd1;
            if (emit_p)
            begin
                r1 = rp;
                n  = 2'd2;
            end
        end
        else if (emit_p)
        begin
            r0 = rp;
            n  = 2'd1;
        end

        if (end_body)
        begin
            if (n == 2'd2)
            begin
                r1.field_end    = 1'b1;
                r1.key_found    = (phase_step != PH_SEARCH);
                r1.value_length = cnt_p;
            end
            else
            begin
                n               = 2'd1;
                r0.field_end    = 1'b1;
                r0.key_found    = (phase_step != PH_SEARCH);
                r0.value_length = cnt_p;
            end
        end

        push.count = acc ? n : 2'd0;
        push.slot0 = r0;
        push.slot1 = r1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_chars_reg  <= KEY_CHARS_RST;
            key_length_reg <= KEY_LENGTH_RST;
            out_limit_reg  <= OUT_LIMIT_RST;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                CFG_KEY_CHARS:  key_chars_reg  <= cfg_data;
                CFG_KEY_LENGTH: key_length_reg <= cfg_data[3:0];
                CFG_OUT_LIMIT:  out_limit_reg  <= cfg_data[7:0];
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg  <= '0;
            since_reg   <= 4'd0;
            phase_reg   <= PH_SEARCH;
            esc_reg     <= ESC_NONE;
            fh_reg      <= 8'd0;
            emitted_reg <= 7'd0;
        end
        else if (acc)
        begin
            window_reg  <= window_next;
            since_reg   <= since_next;
            phase_reg   <= phase_next;
            esc_reg     <= esc_next;
            fh_reg      <= fh_next;
            emitted_reg <= emitted_next;
        end
    end

    // Every body end re-arms the search with a clean count
    a_end_rearm: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && end_body) |=> (phase_reg == PH_SEARCH && emitted_reg == 7'd0
                               && esc_reg == ESC_NONE))
        else $error("front did not re-arm after body end");

endmodule

// ----- rtl/urlfe_queue.sv -----
// ============================================================================
// urlfe_queue: result queue between front and back end
// Small circular buffer that takes up to two beats and gives one per cycle while the back end pops.
// ============================================================================
module urlfe_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  urlfe_pkg::push_t  push,
    output logic              room_for_two,
    output urlfe_pkg::head_t  head,
    input  logic              pop
);
    import urlfe_pkg::*;

    result_t         entry_reg [Q_DEPTH];
    logic [Q_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_AW:0]   count_reg, count_next;
    logic [Q_AW:0]   free;
    logic [Q_AW-1:0] wr_ptr_p1;

    assign free         = (Q_AW+1)'(Q_DEPTH) - count_reg;
    assign room_for_two = (free >= (Q_AW+1)'(2));
    assign head.valid   = (count_reg != '0);
    assign head.data    = entry_reg[rd_ptr_reg];
    assign wr_ptr_p1    = wr_ptr_reg + Q_AW'(1);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + Q_AW'(push.count);
        rd_ptr_next = pop ? rd_ptr_reg + Q_AW'(1) : rd_ptr_reg;
        count_next  = count_reg + (Q_AW+1)'(push.count) - (Q_AW+1)'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0) entry_reg[wr_ptr_reg] <= push.slot0;
        if (push.count == 2'd2) entry_reg[wr_ptr_p1]  <= push.slot1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (Q_AW+1)'(push.count) <= free)
        else $error("queue push exceeds free entries");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head.valid)
        else $error("queue pop while empty");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (Q_AW+1)'(Q_DEPTH))
        else $error("queue count out of range");

endmodule

// ----- rtl/urlfe_back.sv -----
// ============================================================================
// urlfe_back: output stage
// Registers one result beat and holds it while the receiver stalls.
// ============================================================================
module urlfe_back (
    input  logic              clk,
    input  logic              rst_n,
    input  urlfe_pkg::head_t  head,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_stall,
    output urlfe_pkg::result_t out_data
);
    import urlfe_pkg::*;

    logic    out_valid_reg, out_valid_next;
    result_t out_data_reg;
    logic    load_en;

    assign load_en   = !out_valid_reg || !out_stall;
    assign pop       = load_en && head.valid;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        out_valid_next = load_en ? head.valid : out_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (pop) out_data_reg <= head.data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) out_valid_reg <= 1'b0;
        else        out_valid_reg <= out_valid_next;
    end

endmodule

// ----- rtl/urlencoded_field_extractor_unit.sv -----
// ============================================================================
// urlencoded_field_extractor_unit: form body field extractor
// Finds key= in a form-encoded body and streams the percent-decoded value.
// ============================================================================
// Usage
//   Body bytes enter on the input channel (in_valid / in_stall), one beat per
//   byte, body_last on the final byte; a zero byte also ends the body.
//   Result beats leave on the output channel (out_valid / out_stall): one per
//   decoded value byte, and a closing beat with field_end, key_found and
//   value_length. The closing beat may also carry a byte.
//   Write key_chars, key_length and out_limit through cfg_write_en /
//   cfg_index / cfg_data only while no body is in flight.
// Throughput and flow
//   One body byte per cycle while in_stall is low. A byte yields zero, one
//   or two beats; two come only from a truncated escape at body end. The
//   front end writes an accepted byte's results into the four-entry result
//   queue, and the back end loads them from there into the output register
//   as that register frees up.
// Stall and reset
//   in_stall rises when fewer than two queue entries are free, so an
//   output stall backs up into the input after a few beats. A stalled
//   output beat holds. Reset empties the queue, re-arms the key search and
//   loads key_chars 0, key_length 1, out_limit 33.
// ============================================================================
module urlencoded_field_extractor_unit #(
    parameter int KEY_BYTES = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write_en,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  body_byte,
    input  logic        body_last,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  value_byte,
    output logic        byte_valid,
    output logic        field_end,
    output logic        key_found,
    output logic [6:0]  value_length
);
    import urlfe_pkg::*;

    push_t   push;
    head_t   head;
    logic    room_for_two;
    logic    pop;
    result_t out_data;

    // Front end: classify each byte, track key match and escapes
    urlfe_front #(
        .KEY_BYTES (KEY_BYTES)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .body_byte    (body_byte),
        .body_last    (body_last),
        .room_for_two (room_for_two),
        .push         (push)
    );

    // Decouple the two sides; absorbs the two-beat bursts
    urlfe_queue u_queue (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .room_for_two (room_for_two),
        .head         (head),
        .pop          (pop)
    );

    // Back end: output register, hold on stall
    urlfe_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    assign value_byte   = out_data.value_byte;
    assign byte_valid   = out_data.byte_valid;
    assign field_end    = out_data.field_end;
    assign key_found    = out_data.key_found;
    assign value_length = out_data.value_length;

endmodule

// ----- bench/tb.sv -----
// ----------------------------------------------------------------------------
// tb: self-checking bench for urlencoded_field_extractor_unit
// Streams form-encoded bodies into the extractor under random input gaps and
// output stalls, predicts every result beat with an in-bench decoder of the
// key search and percent decoding, and compares each beat field by field.
// ----------------------------------------------------------------------------
module tb;
    import urlfe_pkg::*;

    localparam int KEY_BYTES     = 8;
    localparam int CYCLE_LIMIT   = 1000000;
    // Wait after the last predicted beat; leave margin for the result queue
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASE_BEATS   = 162;
    localparam int RANDOM_PHASES = 12;
    localparam int REPORT_CAP    = 50;
    // Index with no register behind it; a write there must change nothing
    localparam logic [1:0] CFG_SPARE = 2'd3;

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        cfg_write_en = 1'b0;
    logic [1:0]  cfg_index    = 2'd0;
    logic [63:0] cfg_data     = 64'd0;
    logic        in_valid     = 1'b0;
    logic        in_stall;
    logic [7:0]  body_byte    = 8'd0;
    logic        body_last    = 1'b0;
    logic        out_valid;
    logic        out_stall    = 1'b0;
    logic [7:0]  value_byte;
    logic        byte_valid;
    logic        field_end;
    logic        key_found;
    logic [6:0]  value_length;

    // Register copies held by the bench
    logic [63:0] key_reg  = KEY_CHARS_RST;
    logic [3:0]  klen_reg = KEY_LENGTH_RST;
    logic [7:0]  olim_reg = OUT_LIMIT_RST;

    // Per-body decoder state
    logic [63:0] window  = 64'd0;
    logic [3:0]  seen    = 4'd0;
    phase_t      ph      = PH_SEARCH;
    esc_t        esc     = ESC_NONE;
    logic [7:0]  hex_hi  = 8'd0;
    logic [6:0]  emitted = 7'd0;

    result_t     step_beats[$];
    result_t     due_beats[$];
    result_t     want_beat;
    logic [7:0]  body_q[$];

    int          cycles     = 0;
    int          mismatches = 0;
    int          beat_no    = 0;
    int          beats_sent = 0;
    int          stall_left = 0;
    bit          idle_on    = 1'b1;

    urlencoded_field_extractor_unit #(
        .KEY_BYTES(KEY_BYTES)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .body_byte    (body_byte),
        .body_last    (body_last),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .value_byte   (value_byte),
        .byte_valid   (byte_valid),
        .field_end    (field_end),
        .key_found    (key_found),
        .value_length (value_length)
    );

    always #5 clk = ~clk;

    // Hard stop: a hang or a missing beat ends here
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Random pacing: mostly short runs, now and then a long one
    // ------------------------------------------------------------------
    function automatic int stretch_len();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(10, 40);
        return $urandom_range(1, 3);
    endfunction

    function automatic int gap_len();
        int r;
        if (!idle_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Receiver back-pressure
    always @(posedge clk)
    begin
        if (!rst_n || !idle_on)
        begin
            stall_left = 0;
            out_stall <= 1'b0;
        end
        else if (stall_left != 0)
        begin
            stall_left = stall_left - 1;
            out_stall <= 1'b1;
        end
        else if ($urandom_range(0, 3) == 0)
        begin
            stall_left = stretch_len() - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    // ------------------------------------------------------------------
    // Decoder model
    // ------------------------------------------------------------------

    // Bytes allowed in one value: buffer size minus the terminator, max 127
    function automatic int unsigned byte_cap();
        int unsigned l;
        l = (olim_reg == 8'd0) ? 0 : olim_reg - 1;
        if (l > 127)
            l = 127;
        return l;
    endfunction

    function automatic int unsigned key_span();
        int unsigned k;
        k = {28'd0, klen_reg};
        if (k > 8)
            k = 8;
        if (k > KEY_BYTES)
            k = KEY_BYTES;
        return k;
    endfunction

    // Key byte j lines up with window byte k-1-j (newest byte is lowest)
    function automatic bit key_hit();
        int unsigned k;
        logic [7:0]  w;
        logic [7:0]  c;
        k = key_span();
        if (seen < k)
            return 1'b0;
        for (int j = 0; j < k; j++)
        begin
            w = window[8 * (k - 1 - j) +: 8];
            c = key_reg[8 * j +: 8];
            // a zero key byte can never match
            if (c == CH_NUL || w != c)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic int nibble_of(input logic [7:0] c);
        if (c >= "0" && c <= "9")
            return int'(c - "0");
        if (c >= "a" && c <= "f")
            return int'(c - "a") + 10;
        if (c >= "A" && c <= "F")
            return int'(c - "A") + 10;
        return -1;
    endfunction

    // Both digits: full byte; only the first: its value; no first digit: zero
    function automatic logic [7:0] pair_value(input logic [7:0] a, input logic [7:0] b);
        int h;
        int l;
        h = nibble_of(a);
        l = nibble_of(b);
        if (h < 0)
            return 8'd0;
        if (l < 0)
            return 8'(h);
        return 8'(h * 16 + l);
    endfunction

    task automatic emit_value(input logic [7:0] b);
        result_t r;
        r = '0;
        r.value_byte = b;
        r.byte_valid = 1'b1;
        step_beats.push_back(r);
        emitted = emitted + 7'd1;
        if (emitted >= byte_cap())
            ph = PH_DONE;
    endtask

    // Ordinary value byte: ampersand closes, plus is a space
    task automatic copy_plain(input logic [7:0] b);
        if (ph != PH_VALUE)
            return;
        if (emitted >= byte_cap())
        begin
            ph = PH_DONE;
            return;
        end
        if (b == CH_AMP)
            ph = PH_DONE;
        else if (b == CH_PLUS)
            emit_value(CH_SPACE);
        else
            emit_value(b);
    endtask

    // Advance the model by one accepted body byte and queue its beats
    task automatic predict_beat(input logic [7:0] b, input logic last);
        result_t tail;
        esc_t    held;
        step_beats.delete();
        if (b != CH_NUL)
        begin
            if (ph == PH_SEARCH)
            begin
                if (b == CH_EQ && key_hit())
                begin
                    ph = PH_VALUE;
                    if (byte_cap() == 0)
                        ph = PH_DONE;
                end
                window = {window[55:0], b};
                if (seen < 4'd15)
                    seen = seen + 4'd1;
            end
            else if (ph == PH_VALUE)
            begin
                case (esc)
                    ESC_NONE:
                    begin
                        // a percent on the final byte has nothing to decode
                        if (b == CH_PCT && !last)
                            esc = ESC_PCT;
                        else
                            copy_plain(b);
                    end
                    ESC_PCT:
                    begin
                        if (last)
                        begin
                            esc = ESC_NONE;
                            emit_value(CH_PCT);
                            copy_plain(b);
                        end
                        else
                        begin
                            hex_hi = b;
                            esc = ESC_HI;
                        end
                    end
                    default:
                    begin
                        esc = ESC_NONE;
                        emit_value(pair_value(hex_hi, b));
                    end
                endcase
            end
        end
        else if (ph == PH_VALUE && esc != ESC_NONE)
        begin
            // body cut short inside an escape: flush it as plain text
            held = esc;
            esc = ESC_NONE;
            emit_value(CH_PCT);
            if (held == ESC_HI)
                copy_plain(hex_hi);
        end

        if (b == CH_NUL || last)
        begin
            if (step_beats.size() == 0)
                tail = '0;
            else
                tail = step_beats.pop_back();
            tail.field_end    = 1'b1;
            tail.key_found    = (ph != PH_SEARCH);
            tail.value_length = emitted;
            step_beats.push_back(tail);
            window  = 64'd0;
            seen    = 4'd0;
            ph      = PH_SEARCH;
            esc     = ESC_NONE;
            hex_hi  = 8'd0;
            emitted = 7'd0;
        end

        foreach (step_beats[i])
            due_beats.push_back(step_beats[i]);
    endtask

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        if (mismatches < REPORT_CAP)
            $display("beat %0d: %0s got %0h, want %0h", beat_no, what, got, want);
        mismatches++;
    endtask

    // Compare each accepted beat against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            beat_no++;
            if (due_beats.size() == 0)
                report_mismatch("unexpected beat, value_byte", value_byte, 8'd0);
            else
            begin
                want_beat = due_beats.pop_front();
                if (value_byte !== want_beat.value_byte)
                    report_mismatch("value_byte", value_byte, want_beat.value_byte);
                if (byte_valid !== want_beat.byte_valid)
                    report_mismatch("byte_valid", 8'(byte_valid),
                                    8'(want_beat.byte_valid));
                if (field_end !== want_beat.field_end)
                    report_mismatch("field_end", 8'(field_end),
                                    8'(want_beat.field_end));
                if (key_found !== want_beat.key_found)
                    report_mismatch("key_found", 8'(key_found),
                                    8'(want_beat.key_found));
                if (value_length !== want_beat.value_length)
                    report_mismatch("value_length", 8'(value_length),
                                    8'(want_beat.value_length));
            end
        end
    end

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Hold one body byte until accepted, then advance the model
    task automatic send_body_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = gap_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        body_byte <= b;
        body_last <= last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_beat(b, last);
        beats_sent++;
    endtask

    task automatic send_text(input string s, input bit mark_last);
        for (int i = 0; i < s.len(); i++)
            send_body_byte(s[i], mark_last && (i == s.len() - 1));
    endtask

    // Drop valid, let every predicted beat arrive, then settle
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (due_beats.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write enable stays high across back-to-back writes
    task automatic write_reg(input logic [1:0] idx, input logic [63:0] data);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= data;
        @(posedge clk);
        case (idx)
            CFG_KEY_CHARS:  key_reg  = data;
            CFG_KEY_LENGTH: klen_reg = data[3:0];
            CFG_OUT_LIMIT:  olim_reg = data[7:0];
            default: ;
        endcase
    endtask

    // Load all three registers; upper data bits carry junk that must be ignored
    task automatic load_key(input logic [63:0] kc, input logic [3:0] kl,
                            input logic [7:0] ol);
        logic [63:0] junk;
        write_reg(CFG_KEY_CHARS, kc);
        junk = {$urandom, $urandom};
        write_reg(CFG_KEY_LENGTH, {junk[63:4], kl});
        junk = {$urandom, $urandom};
        write_reg(CFG_OUT_LIMIT, {junk[63:8], ol});
        cfg_write_en <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Character pickers
    // ------------------------------------------------------------------
    function automatic logic [7:0] letter();
        return 8'("a" + $urandom_range(0, 25));
    endfunction

    function automatic logic [7:0] hex_char();
        int r;
        r = $urandom_range(0, 21);
        if (r < 10)
            return 8'("0" + r);
        if (r < 16)
            return 8'("a" + r - 10);
        return 8'("A" + r - 16);
    endfunction

    function automatic logic [7:0] non_hex();
        logic [7:0] c;
        do
            c = 8'($urandom_range(1, 255));
        while (nibble_of(c) >= 0);
        return c;
    endfunction

    function automatic logic [7:0] any_char();
        if ($urandom_range(0, 1) == 0)
            return letter();
        return 8'($urandom_range(1, 255));
    endfunction

    function automatic logic [63:0] random_key();
        logic [63:0] kc;
        for (int i = 0; i < 8; i++)
            kc[8 * i +: 8] = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(1, 255))
                                                          : letter();
        return kc;
    endfunction

    // Build one body in body_q: mostly decoys then key= and an encoded value,
    // some with a damaged key, some plain noise
    task automatic build_body(output bit mark_last);
        int kind;
        int k;
        int n;
        int cut;
        int r;
        body_q.delete();
        k = key_span();
        kind = $urandom_range(0, 9);
        if (kind <= 8)
        begin
            repeat ($urandom_range(0, 2))
            begin
                // decoy field, sometimes starting with most of the key
                if ($urandom_range(0, 2) == 0 && k > 1)
                    for (int j = 0; j < k - 1; j++)
                        body_q.push_back(key_reg[8 * j +: 8]);
                repeat ($urandom_range(1, 3)) body_q.push_back(letter());
                body_q.push_back(CH_EQ);
                repeat ($urandom_range(0, 3)) body_q.push_back(letter());
                body_q.push_back(CH_AMP);
            end
            cut = (kind >= 7) ? $urandom_range(0, k) : k;
            for (int j = 0; j < cut; j++)
                body_q.push_back(key_reg[8 * j +: 8]);
            if (kind == 8)
                body_q.push_back(letter());
            body_q.push_back(CH_EQ);
            n = ($urandom_range(0, 4) == 0) ? $urandom_range(0, byte_cap() + 4)
                                             : $urandom_range(0, 12);
            repeat (n)
            begin
                r = $urandom_range(0, 19);
                if (r <= 9)
                    body_q.push_back(any_char());
                else if (r <= 11)
                    body_q.push_back(CH_PLUS);
                else if (r <= 14)
                begin
                    body_q.push_back(CH_PCT);
                    body_q.push_back(hex_char());
                    body_q.push_back(hex_char());
                end
                else if (r == 15)
                begin
                    body_q.push_back(CH_PCT);
                    body_q.push_back(hex_char());
                    body_q.push_back(non_hex());
                end
                else if (r == 16)
                begin
                    body_q.push_back(CH_PCT);
                    body_q.push_back(non_hex());
                    body_q.push_back(any_char());
                end
                else if (r == 17)
                    body_q.push_back(CH_AMP);
                else
                    body_q.push_back(letter());
            end
            // leave an escape open at the end now and then
            r = $urandom_range(0, 9);
            if (r == 0)
                body_q.push_back(CH_PCT);
            else if (r == 1)
            begin
                body_q.push_back(CH_PCT);
                body_q.push_back(any_char());
            end
        end
        else
        begin
            repeat ($urandom_range(1, 20))
            begin
                r = $urandom_range(0, 5);
                case (r)
                    0: body_q.push_back(CH_EQ);
                    1: body_q.push_back(CH_AMP);
                    2: body_q.push_back(CH_PCT);
                    3: body_q.push_back(CH_PLUS);
                    4: body_q.push_back(letter());
                    default: body_q.push_back(8'($urandom_range(0, 255)));
                endcase
            end
        end

        // Close by body_last, by a zero byte, or by a zero byte that is also last
        r = $urandom_range(0, 9);
        if (r < 6)
        begin
            if (body_q.size() == 0)
                body_q.push_back(any_char());
            mark_last = 1'b1;
        end
        else
        begin
            body_q.push_back(CH_NUL);
            mark_last = (r >= 8);
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset key is a single zero byte, which never matches
    task automatic test_reset_key();
        write_reg(CFG_SPARE, {$urandom, $urandom});
        cfg_write_en <= 1'b0;
        send_text("=x", 1'b1);
        wait_drained();
    endtask

    // Plus, full hex pair, first digit only, no digits, then ampersand ends the
    // value and the trailing byte is ignored
    task automatic test_value_decode();
        load_key(64'h6B, 4'd1, 8'd33);   // key "k"
        send_text("k=+%41%4g%zz&q", 1'b1);
        wait_drained();
    endtask

    // Escape cut by a zero byte, and a percent plus one byte at body_last
    task automatic test_truncated_escape();
        send_text("k=%4", 1'b0);
        send_body_byte(CH_NUL, 1'b0);
        send_text("k=%x", 1'b1);
        wait_drained();
    endtask

    // Phases of random bodies, each under its own register setting
    task automatic test_random_bodies();
        logic [63:0] kc;
        int          kl;
        int          ol;
        int          phase_start;
        bit          mark;
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            kc = random_key();
            kl = $urandom_range(1, 8);
            ol = $urandom_range(0, 1) ? $urandom_range(1, 12) : $urandom_range(13, 128);
            case (p)
                0: kl = 0;                                  // empty key
                1: begin kl = 8; ol = 128; end
                2: begin kl = 15; ol = 255; end             // long key, big limit
                3: begin kl = 9; ol = 0; end                // no bytes allowed
                4: begin kl = 1; ol = 1; end
                5: begin kl = 3; kc[15:8] = CH_NUL; ol = 2; end  // unmatchable key
                6: begin kc = '1; kl = 8; ol = 129; end
                default: ;
            endcase
            // two phases run with no gaps and no stalls
            idle_on = (p != 7 && p != 8);
            load_key(kc, kl[3:0], ol[7:0]);
            phase_start = beats_sent;
            while (beats_sent - phase_start < PHASE_BEATS)
            begin
                build_body(mark);
                foreach (body_q[i])
                    send_body_byte(body_q[i], mark && (i == body_q.size() - 1));
            end
            wait_drained();
        end
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_key();
        test_value_decode();
        test_truncated_escape();
        test_random_bodies();
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ----- urlencoded_field_extractor_unit.f -----
rtl/urlfe_pkg.sv
rtl/urlfe_front.sv
rtl/urlfe_queue.sv
rtl/urlfe_back.sv
rtl/urlencoded_field_extractor_unit.sv
bench/tb.sv
